/* rtl/cpq_pkg.sv */
package cpq_pkg;

  localparam int CREDIT_DEPTH = 16;
  localparam int DATA_DEPTH = 64;
  localparam int CAW = $clog2(CREDIT_DEPTH);
  localparam int DAW = $clog2(DATA_DEPTH);

  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_DONE = 2'd2;

  localparam logic [2:0] RK_ACCEPT = 3'd0;
  localparam logic [2:0] RK_DROP = 3'd1;
  localparam logic [2:0] RK_CSTART = 3'd2;
  localparam logic [2:0] RK_DSTART = 3'd3;
  localparam logic [2:0] RK_DONE = 3'd4;

  localparam logic [1:0] TX_NONE = 2'd0;
  localparam logic [1:0] TX_CREDIT = 2'd1;
  localparam logic [1:0] TX_DATA = 2'd2;

  localparam logic [1:0] REG_SPACING = 2'd0;
  localparam logic [1:0] REG_CAP = 2'd1;
  localparam logic [1:0] REG_CLIMIT = 2'd2;
  localparam logic [1:0] REG_DLIMIT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the input item
    logic arrive;   // perform the arrival step, emit accept or drop
    logic tick;     // perform the tick step
    logic finish;   // perform the link-finished step
    logic serve;    // run begin-service
  } cpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_arrive;
    logic op_tick;
    logic op_done;
    logic arrive_serve;  // accepted into an empty, idle system
    logic tick_serve;    // token earned while waiting and idle
    logic done_serve;    // completion and work remains
  } cpq_stat_t;

endpackage

/* rtl/credit_paced_two_queue_scheduler.sv */
// Two-queue output port scheduler with token-paced credit packets.
// Input channel: an item (operation, pkt_is_credit, pkt_bytes, pkt_tag) transfers at a
// clock edge where start is high and busy is low. Operation 0 is a packet arrival,
// 1 a time tick and 2 a link-finished report; other codes are ignored.
// Results appear on result_kind, out_tag, out_bytes and last for one cycle, marked
// by result_valid. The receiver cannot stall, so every result is taken at once.
// The item is latched at the transfer edge, and its first result is then registered
// from the latched copy in the execute state. An item that gives at most one result
// needs only the execute state; an accepted arrival into an empty idle port or a
// completion with work remaining then passes through a fetch state, which reads the
// new queue head from storage, and a serve state, which runs begin-service on the
// updated queue state, so any start result follows the first result.
// The controller handles one item at a time, so busy stays high while it is in these states.
// Configuration: cfg_ready is always high, and cfg_valid with cfg_index and cfg_data
// writes a register; the user must do this while the block is idle, unchecked by it.
// Reset (rst, synchronous) empties both queues, clears byte counts and the tick
// counter, sets one banked token and restores register defaults. Queue storage
// itself is not cleared; it is only read after being written.
module credit_paced_two_queue_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic        pkt_is_credit,
  input  logic [13:0] pkt_bytes,
  input  logic [15:0] pkt_tag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [2:0]  result_kind,
  output logic [15:0] out_tag,
  output logic [13:0] out_bytes,
  output logic        last
);
  import cpq_pkg::*;

  cpq_cmd_t  cmd;
  cpq_stat_t stat;

  assign cfg_ready = 1'b1;

  // Controller sequences each item; datapath holds queues and token bucket.
  cpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  cpq_dp u_dp (
    .clk(clk), .rst(rst),
    .operation(operation), .pkt_is_credit(pkt_is_credit),
    .pkt_bytes(pkt_bytes), .pkt_tag(pkt_tag),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat),
    .result_valid(result_valid), .result_kind(result_kind),
    .out_tag(out_tag), .out_bytes(out_bytes), .last(last)
  );
endmodule

/* rtl/cpq_ctrl.sv */
module cpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cpq_pkg::cpq_stat_t stat,
  output cpq_pkg::cpq_cmd_t  cmd
);
  import cpq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FETCH, S_SERVE} state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    cmd.latch = start && state == S_IDLE;
    case (state)
      S_EXEC: begin
        cmd.arrive = stat.op_arrive;
        cmd.tick = stat.op_tick;
        cmd.finish = stat.op_done;
        cmd.serve = stat.op_tick && stat.tick_serve;
      end
      S_SERVE: cmd.serve = 1'b1;
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;

  // S_FETCH lets the queue head registers take up the updated head before S_SERVE.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (start) state <= S_EXEC;
        S_EXEC: begin
          if ((stat.op_arrive && stat.arrive_serve) ||
              (stat.op_done && stat.done_serve)) state <= S_FETCH;
          else state <= S_IDLE;
        end
        S_FETCH: state <= S_SERVE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/cpq_dp.sv */
module cpq_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        operation,
  input  logic              pkt_is_credit,
  input  logic [13:0]       pkt_bytes,
  input  logic [15:0]       pkt_tag,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  cpq_pkg::cpq_cmd_t  cmd,
  output cpq_pkg::cpq_stat_t stat,
  output logic              result_valid,
  output logic [2:0]        result_kind,
  output logic [15:0]       out_tag,
  output logic [13:0]       out_bytes,
  output logic              last
);
  import cpq_pkg::*;

  logic [31:0] spacing;
  logic [7:0]  cap;
  logic [23:0] climit, dlimit;

  logic [1:0]  op;
  logic        is_c;
  logic [13:0] bytes;
  logic [15:0] tag;

  logic [29:0] cmem [CREDIT_DEPTH];
  logic [29:0] dmem [DATA_DEPTH];
  logic [CAW-1:0] crd;
  logic [DAW-1:0] drd;
  logic [CAW:0]   ccnt;
  logic [DAW:0]   dcnt;
  logic [23:0] cbytes, dbytes;
  logic [7:0]  tokens;
  logic [31:0] ticks;
  logic [1:0]  txk;
  logic        waiting;

  // Queue heads are read every cycle into registers.
  logic [29:0] chead, dhead;
  always_ff @(posedge clk) begin
    chead <= cmem[crd];
    dhead <= dmem[drd];
  end

  always_ff @(posedge clk) begin
    if (cfg_valid) begin
      case (cfg_index)
        REG_SPACING: spacing <= cfg_data;
        REG_CAP:     cap <= cfg_data[7:0];
        REG_CLIMIT:  climit <= cfg_data[23:0];
        REG_DLIMIT:  dlimit <= cfg_data[23:0];
        default: ;
      endcase
    end
    if (rst) begin
      spacing <= 32'd1575;
      cap <= 8'd2;
      climit <= 24'd512;
      dlimit <= 24'd65536;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op <= operation;
      is_c <= pkt_is_credit;
      bytes <= pkt_bytes;
      tag <= pkt_tag;
    end
  end

  // Arrival checks.
  logic [24:0] qsum;
  logic        full, drop, was_empty;
  assign qsum = is_c ? ({1'b0, cbytes} + 25'(bytes)) : ({1'b0, dbytes} + 25'(bytes));
  assign full = is_c ? (ccnt == (CAW+1)'(CREDIT_DEPTH)) : (dcnt == (DAW+1)'(DATA_DEPTH));
  assign drop = (qsum > {1'b0, (is_c ? climit : dlimit)}) || full;
  assign was_empty = ccnt == '0 && dcnt == '0;

  // Tick checks.
  logic [32:0] tnext;
  logic        earn;
  logic [8:0]  tinc;
  assign tnext = {1'b0, ticks} + 33'd1;
  assign earn = tnext >= {1'b0, spacing};
  assign tinc = {1'b0, tokens} + 9'd1;

  // Finish checks.
  logic fin_c, fin_d;
  assign fin_c = txk == TX_CREDIT && ccnt != '0;
  assign fin_d = txk == TX_DATA && dcnt != '0;

  // Whether begin-service after a completion will start a packet.
  logic done_more;
  assign done_more = fin_c ? ((ccnt > (CAW+1)'(1) && tokens != '0) || dcnt != '0)
                           : (fin_d && ((ccnt != '0 && tokens != '0) ||
                                        dcnt > (DAW+1)'(1)));

  // Begin-service decision on current state.
  logic svc_c, svc_d;
  assign svc_c = ccnt != '0 && tokens != '0;
  assign svc_d = !svc_c && dcnt != '0;

  always_comb begin
    stat.op_arrive = op == OP_ARRIVE;
    stat.op_tick = op == OP_TICK;
    stat.op_done = op == OP_DONE;
    stat.arrive_serve = !drop && was_empty && txk == TX_NONE;
    stat.tick_serve = earn && waiting && txk == TX_NONE;
    stat.done_serve = fin_c ? (ccnt > (CAW+1)'(1) || dcnt != '0)
                            : (fin_d && (ccnt != '0 || dcnt > (DAW+1)'(1)));
  end

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (cmd.arrive) begin
      result_valid <= 1'b1;
      result_kind <= drop ? RK_DROP : RK_ACCEPT;
      out_tag <= tag;
      out_bytes <= bytes;
      // A lone credit packet with no token starts nothing.
      last <= drop || !stat.arrive_serve || (is_c && tokens == '0);
      if (!drop) begin
        if (is_c) begin
          cmem[crd + ccnt[CAW-1:0]] <= {tag, bytes};
          ccnt <= ccnt + 1'b1;
          cbytes <= qsum[23:0];
        end else begin
          dmem[drd + dcnt[DAW-1:0]] <= {tag, bytes};
          dcnt <= dcnt + 1'b1;
          dbytes <= qsum[23:0];
        end
      end
    end
    if (cmd.tick) begin
      if (earn) begin
        ticks <= '0;
        tokens <= (tinc > {1'b0, cap}) ? cap : tinc[7:0];
      end else begin
        ticks <= tnext[31:0];
      end
    end
    if (cmd.finish) begin
      txk <= TX_NONE;
      if (fin_c || fin_d) begin
        result_valid <= 1'b1;
        result_kind <= RK_DONE;
        out_tag <= fin_c ? chead[29:14] : dhead[29:14];
        out_bytes <= fin_c ? chead[13:0] : dhead[13:0];
        last <= !done_more;
      end
      if (fin_c) begin
        crd <= crd + 1'b1;
        ccnt <= ccnt - 1'b1;
        cbytes <= cbytes - 24'(chead[13:0]);
      end else if (fin_d) begin
        drd <= drd + 1'b1;
        dcnt <= dcnt - 1'b1;
        dbytes <= dbytes - 24'(dhead[13:0]);
      end
    end
    // A tick serve sees tokens updated in the same step.
    if (cmd.serve) begin
      if (cmd.tick) begin
        if (ccnt != '0 && ((tinc > {1'b0, cap}) ? cap : tinc[7:0]) != '0) begin
          tokens <= ((tinc > {1'b0, cap}) ? cap : tinc[7:0]) - 8'd1;
          waiting <= 1'b0;
          txk <= TX_CREDIT;
          result_valid <= 1'b1;
          result_kind <= RK_CSTART;
          out_tag <= chead[29:14];
          out_bytes <= chead[13:0];
          last <= 1'b1;
        end else if (dcnt != '0) begin
          txk <= TX_DATA;
          result_valid <= 1'b1;
          result_kind <= RK_DSTART;
          out_tag <= dhead[29:14];
          out_bytes <= dhead[13:0];
          last <= 1'b1;
        end else begin
          waiting <= 1'b1;
        end
      end else if (svc_c) begin
        tokens <= tokens - 8'd1;
        waiting <= 1'b0;
        txk <= TX_CREDIT;
        result_valid <= 1'b1;
        result_kind <= RK_CSTART;
        out_tag <= chead[29:14];
        out_bytes <= chead[13:0];
        last <= 1'b1;
      end else if (svc_d) begin
        txk <= TX_DATA;
        result_valid <= 1'b1;
        result_kind <= RK_DSTART;
        out_tag <= dhead[29:14];
        out_bytes <= dhead[13:0];
        last <= 1'b1;
      end else begin
        waiting <= 1'b1;
      end
    end
    if (rst) begin
      result_valid <= 1'b0;
      crd <= '0;
      drd <= '0;
      ccnt <= '0;
      dcnt <= '0;
      cbytes <= '0;
      dbytes <= '0;
      tokens <= 8'd1;
      ticks <= '0;
      txk <= TX_NONE;
      waiting <= 1'b0;
    end
  end
endmodule

/* sim/scheduler_checker.sv */
`timescale 1ns / 1ps

// Watches the item, configuration and result channels of the scheduler,
// keeps its own copy of the queue and token state, and compares every
// result with the oldest one predicted.
module scheduler_checker
  import cpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic        pkt_is_credit,
  input  logic [13:0] pkt_bytes,
  input  logic [15:0] pkt_tag,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        result_valid,
  input  logic [2:0]  result_kind,
  input  logic [15:0] out_tag,
  input  logic [13:0] out_bytes,
  input  logic        last,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [15:0] tag;
    logic [13:0] bytes;
  } pkt_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] tag;
    logic [13:0] bytes;
    logic        last;
  } sched_result_t;

  // Register copies.
  logic [31:0] spacing;
  logic [7:0]  cap;
  logic [23:0] climit;
  logic [23:0] dlimit;

  // Port state.
  pkt_t        cfifo [CREDIT_DEPTH];
  pkt_t        dfifo [DATA_DEPTH];
  int          crd, ccount, drd, dcount;
  longint      cbytes, dbytes;
  int          tokens;
  longint      ticks;
  logic [1:0]  tx_kind;
  logic        waiting;

  sched_result_t step_results[$];
  sched_result_t expected_results[$];

  function automatic void note(logic [2:0] kind, pkt_t p);
    sched_result_t r;
    r.kind = kind;
    r.tag = p.tag;
    r.bytes = p.bytes;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void begin_service();
    if (ccount > 0 && tokens > 0) begin
      tokens--;
      waiting = 1'b0;
      tx_kind = TX_CREDIT;
      note(RK_CSTART, cfifo[crd]);
    end else if (dcount > 0) begin
      tx_kind = TX_DATA;
      note(RK_DSTART, dfifo[drd]);
    end else begin
      waiting = 1'b1;
    end
  endfunction

  function automatic void predict_item(logic [1:0] op, logic isc, logic [13:0] nbytes,
                                       logic [15:0] tag);
    pkt_t   p;
    logic   was_empty;
    longint limit;
    int     t;
    p.tag = tag;
    p.bytes = nbytes;
    step_results.delete();
    if (op == OP_ARRIVE) begin
      was_empty = (ccount == 0 && dcount == 0);
      if (isc) begin
        limit = climit;
        if (cbytes + nbytes > limit || ccount >= CREDIT_DEPTH) begin
          note(RK_DROP, p);
        end else begin
          cfifo[(crd + ccount) % CREDIT_DEPTH] = p;
          ccount++;
          cbytes += nbytes;
          note(RK_ACCEPT, p);
          if (was_empty && tx_kind == TX_NONE) begin
            begin_service();
          end
        end
      end else begin
        limit = dlimit;
        if (dbytes + nbytes > limit || dcount >= DATA_DEPTH) begin
          note(RK_DROP, p);
        end else begin
          dfifo[(drd + dcount) % DATA_DEPTH] = p;
          dcount++;
          dbytes += nbytes;
          note(RK_ACCEPT, p);
          if (was_empty && tx_kind == TX_NONE) begin
            begin_service();
          end
        end
      end
    end else if (op == OP_TICK) begin
      if (ticks + 1 >= longint'(spacing)) begin
        t = tokens + 1;
        tokens = (t > int'(cap)) ? int'(cap) : t;
        ticks = 0;
        if (waiting && tx_kind == TX_NONE) begin
          begin_service();
        end
      end else begin
        ticks++;
      end
    end else if (op == OP_DONE) begin
      if (tx_kind == TX_CREDIT && ccount > 0) begin
        note(RK_DONE, cfifo[crd]);
        cbytes -= cfifo[crd].bytes;
        crd = (crd + 1) % CREDIT_DEPTH;
        ccount--;
      end else if (tx_kind == TX_DATA && dcount > 0) begin
        note(RK_DONE, dfifo[drd]);
        dbytes -= dfifo[drd].bytes;
        drd = (drd + 1) % DATA_DEPTH;
        dcount--;
      end
      // A completion with nothing in flight is ignored but still idles the link.
      t = step_results.size();
      tx_kind = TX_NONE;
      if (t > 0 && (ccount > 0 || dcount > 0)) begin
        begin_service();
      end
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
    foreach (step_results[i]) begin
      expected_results.push_back(step_results[i]);
    end
  endfunction

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst) begin
      spacing = 32'd1575;
      cap = 8'd2;
      climit = 24'd512;
      dlimit = 24'd65536;
      crd = 0;
      ccount = 0;
      drd = 0;
      dcount = 0;
      cbytes = 0;
      dbytes = 0;
      tokens = 1;
      ticks = 0;
      tx_kind = TX_NONE;
      waiting = 1'b0;
      expected_results.delete();
    end else begin
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d tag %0h bytes %0d", result_kind, out_tag,
                 out_bytes);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_kind !== exp_r.kind) begin
            $error("result_kind: expected %0d, actual %0d", exp_r.kind, result_kind);
            errors++;
          end
          if (out_tag !== exp_r.tag) begin
            $error("out_tag: expected %0h, actual %0h", exp_r.tag, out_tag);
            errors++;
          end
          if (out_bytes !== exp_r.bytes) begin
            $error("out_bytes: expected %0d, actual %0d", exp_r.bytes, out_bytes);
            errors++;
          end
          if (last !== exp_r.last) begin
            $error("last: expected %0d, actual %0d", exp_r.last, last);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPACING: spacing = cfg_data;
          REG_CAP: cap = cfg_data[7:0];
          REG_CLIMIT: climit = cfg_data[23:0];
          REG_DLIMIT: dlimit = cfg_data[23:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_item(operation, pkt_is_credit, pkt_bytes, pkt_tag);
      end
    end
    outstanding <= expected_results.size();
  end

  initial begin
    errors = 0;
    outstanding = 0;
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

// Top level of the scheduler testbench. It drives items and register
// writes into the block and gives the verdict; all prediction and
// comparison happens in the checker that sits beside the block.
module testbench;
  import cpq_pkg::*;

  // Cycles without any transfer after which the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  // Cycles to let pass after the last expected result, since an item that
  // gives no result may still be in flight.
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int PHASES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = OP_TICK;
  logic        pkt_is_credit = 1'b0;
  logic [13:0] pkt_bytes = '0;
  logic [15:0] pkt_tag = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SPACING;
  logic [31:0] cfg_data = '0;
  logic        result_valid;
  logic [2:0]  result_kind;
  logic [15:0] out_tag;
  logic [13:0] out_bytes;
  logic        last;
  int          errors;
  int          outstanding;
  int          quiet_cycles = 0;
  // When set, items follow one another with no idle cycles between them.
  bit          back_to_back = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  credit_paced_two_queue_scheduler i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .pkt_is_credit(pkt_is_credit), .pkt_bytes(pkt_bytes), .pkt_tag(pkt_tag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .result_kind(result_kind),
    .out_tag(out_tag), .out_bytes(out_bytes), .last(last)
  );

  scheduler_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .pkt_is_credit(pkt_is_credit), .pkt_bytes(pkt_bytes), .pkt_tag(pkt_tag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .result_kind(result_kind),
    .out_tag(out_tag), .out_bytes(out_bytes), .last(last),
    .errors(errors), .outstanding(outstanding)
  );

  // The watchdog is cleared by any transfer on any channel. Every wait in
  // the stimulus is bounded by the idle draw, the item length or the
  // settle time, all far below the limit on a healthy block.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Sends one item. Start stays high across back-to-back items so that it
  // is never lowered and raised within the same edge.
  task automatic send_item(logic [1:0] op, logic isc, logic [13:0] nbytes,
                           logic [15:0] tag);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    pkt_is_credit <= isc;
    pkt_bytes <= nbytes;
    pkt_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Returns once every predicted result has come and the block has had
  // time to finish an item that gives none. The first edge lets the
  // checker's count catch up with the last transfer.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [31:0] spc, logic [7:0] cp, logic [23:0] cl,
                           logic [23:0] dl);
    wait_idle();
    write_reg(REG_SPACING, spc);
    write_reg(REG_CAP, {24'd0, cp});
    write_reg(REG_CLIMIT, {8'd0, cl});
    write_reg(REG_DLIMIT, {8'd0, dl});
  endtask

  // Random item: mostly arrivals and ticks with small packets so that the
  // queues fill, drain and hit the full and byte-limit cases, plus link
  // completions and the odd unused operation code.
  task automatic send_random_item();
    int          pick;
    logic [1:0]  op;
    logic [13:0] nbytes;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      op = OP_ARRIVE;
    end else if (pick < 72) begin
      op = OP_TICK;
    end else if (pick < 95) begin
      op = OP_DONE;
    end else begin
      op = 2'd3;
    end
    nbytes = ($urandom_range(0, 9) < 8) ? 14'($urandom_range(0, 600)) : 14'($urandom);
    send_item(op, 1'($urandom), nbytes, 16'($urandom));
  endtask

  initial begin
    logic [31:0] spc;
    logic [7:0]  cp;
    logic [23:0] cl, dl;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: a completion and an unused code
    // on an idle link, a credit packet taking the banked token, a drop on
    // the credit byte limit, a data packet served after the credit one, and
    // a data packet held back while a credit packet waits for a token.
    send_item(OP_DONE, 1'b0, 14'd0, 16'h0000);
    send_item(2'd3, 1'b1, 14'h3FFF, 16'hFFFF);
    send_item(OP_ARRIVE, 1'b1, 14'd100, 16'hFFFF);
    send_item(OP_ARRIVE, 1'b1, 14'h3FFF, 16'h1234);
    send_item(OP_ARRIVE, 1'b0, 14'd0, 16'h0000);
    send_item(OP_DONE, 1'b0, 14'd0, 16'h0000);
    send_item(OP_ARRIVE, 1'b1, 14'd200, 16'h00A5);
    send_item(OP_DONE, 1'b0, 14'd0, 16'h0000);
    send_item(OP_ARRIVE, 1'b0, 14'h3FFF, 16'h5A5A);

    // Short spacing so the waiting credit packet gets a token from ticks.
    configure(32'd2, 8'd2, 24'd512, 24'd65536);
    send_item(OP_TICK, 1'b0, 14'd0, 16'h0000);
    send_item(OP_TICK, 1'b1, 14'h3FFF, 16'hFFFF);
    send_item(OP_DONE, 1'b0, 14'd0, 16'h0000);
    send_item(OP_DONE, 1'b0, 14'd0, 16'h0000);
    send_item(OP_DONE, 1'b0, 14'd0, 16'h0000);

    // Zero byte limits: only empty packets get in.
    configure(32'd1, 8'd1, 24'd0, 24'd0);
    send_item(OP_ARRIVE, 1'b1, 14'd1, 16'h0001);
    send_item(OP_ARRIVE, 1'b0, 14'd1, 16'h0002);
    send_item(OP_ARRIVE, 1'b0, 14'd0, 16'h0003);
    send_item(OP_ARRIVE, 1'b1, 14'd0, 16'h0004);
    send_item(OP_DONE, 1'b0, 14'd0, 16'h0000);
    send_item(OP_TICK, 1'b0, 14'd0, 16'h0000);
    send_item(OP_DONE, 1'b0, 14'd0, 16'h0000);

    // Random phases. The first three hit the register extremes and the fourth uses the
    // reset settings; the rest draw settings at random. Every third phase runs with no idle cycles.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          spc = 32'd1; cp = 8'd255; cl = 24'hFFFFFF; dl = 24'hFFFFFF;
        end
        1: begin
          spc = 32'hFFFFFFFF; cp = 8'd1; cl = 24'd2000; dl = 24'd4000;
        end
        2: begin
          spc = 32'd3; cp = 8'd1; cl = 24'hFFFFFF; dl = 24'd0;
        end
        3: begin
          spc = 32'd1575; cp = 8'd2; cl = 24'd512; dl = 24'd65536;
        end
        default: begin
          spc = $urandom_range(1, 8);
          cp = 8'($urandom_range(1, 255));
          cl = 24'($urandom_range(0, 6000));
          dl = ($urandom_range(0, 1) == 1) ? 24'($urandom) : 24'($urandom_range(0, 20000));
        end
      endcase
      configure(spc, cp, cl, dl);
      back_to_back = (ph % 3 == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random_item();
      end
    end
    back_to_back = 1'b0;

    wait_idle();
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
